>>> hdl/vcst_pkg.sv
// ----------------------------------------------------------------------------
// vcst_pkg
// Shared widths, constants, register codes and datapath step functions for
// the view-cone sphere test.
// ----------------------------------------------------------------------------
package vcst_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STAGES  = 17;   // two root bits per stage, 34 bits

   localparam int POS_W  = 32;
   localparam int OFS_W  = 33;
   localparam int RAD_W  = 31;
   localparam int FWD_W  = 16;
   localparam int FOV_W  = 15;
   localparam int D2_W   = 66;
   localparam int ROOT_W = 34;
   localparam int REM_W  = 36;
   localparam int TERM_W = 49;
   localparam int DOT_W  = 51;
   localparam int PROD_W = 51;
   localparam int AX_W   = 37;   // vectoring x/y
   localparam int AZ_W   = 19;   // vectoring angle
   localparam int CX_W   = 34;   // rotation x/y, Q.30
   localparam int CT_W   = 21;   // rotation angle
   localparam int COS_W  = 16;   // signed Q.14 cosine

   localparam logic signed [CT_W-1:0] PI_Q16      = 21'sd205887;
   localparam logic signed [CT_W-1:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [CT_W-1:0] TWO_PI_Q16  = 21'sd411775;
   localparam logic signed [CX_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic [D2_W-1:0]        NEAR_D2     = 66'd43;
   localparam logic [17:0]            COS_ONE     = 18'd16384;

   typedef enum logic [2:0] {
      CSR_CAM_X = 3'd0,
      CSR_CAM_Y = 3'd1,
      CSR_CAM_Z = 3'd2,
      CSR_FWD_X = 3'd3,
      CSR_FWD_Y = 3'd4,
      CSR_FWD_Z = 3'd5,
      CSR_FOV   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic signed [AX_W-1:0] x;
      logic signed [AX_W-1:0] y;
      logic signed [AZ_W-1:0] z;
   } ac_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CT_W-1:0] t;
   } cc_type;

   // Arctangent of 2^-s in Q.16, rounded to nearest.
   function automatic logic [15:0] atan_q16(input logic [4:0] s);
      logic [15:0] v;
      case (s)
         5'd0:    v = 16'd51472;
         5'd1:    v = 16'd30385;
         5'd2:    v = 16'd16055;
         5'd3:    v = 16'd8150;
         5'd4:    v = 16'd4091;
         5'd5:    v = 16'd2047;
         5'd6:    v = 16'd1024;
         5'd7:    v = 16'd512;
         5'd8:    v = 16'd256;
         5'd9:    v = 16'd128;
         5'd10:   v = 16'd64;
         5'd11:   v = 16'd32;
         5'd12:   v = 16'd16;
         5'd13:   v = 16'd8;
         5'd14:   v = 16'd4;
         5'd15:   v = 16'd2;
         5'd16:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // One digit of the restoring square root: bring in one bit pair.
   function automatic sq_type sqrt_step(input sq_type cur, input logic [1:0] pair);
      sq_type            nxt;
      logic [REM_W+1:0]  part;
      logic [REM_W+1:0]  trial;
      part  = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      if (part >= trial) begin
         nxt.rem  = REM_W'(part - trial);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = part[REM_W-1:0];
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // One vectoring micro-rotation: drive y toward zero, gather the angle.
   function automatic ac_type atan_step(input ac_type cur, input logic [4:0] s);
      ac_type                 nxt;
      logic signed [AZ_W-1:0] ang;
      ang = $signed({3'b000, atan_q16(s)});
      if (cur.y >= 0) begin
         nxt.x = cur.x + (cur.y >>> s);
         nxt.y = cur.y - (cur.x >>> s);
         nxt.z = cur.z + ang;
      end else begin
         nxt.x = cur.x - (cur.y >>> s);
         nxt.y = cur.y + (cur.x >>> s);
         nxt.z = cur.z - ang;
      end
      return nxt;
   endfunction

   // One rotation micro-step: turn the vector by the residual angle.
   function automatic cc_type cos_step(input cc_type cur, input logic [4:0] s);
      cc_type                 nxt;
      logic signed [CT_W-1:0] ang;
      ang = $signed({5'b00000, atan_q16(s)});
      if (cur.t >= 0) begin
         nxt.x = cur.x - (cur.y >>> s);
         nxt.y = cur.y + (cur.x >>> s);
         nxt.t = cur.t - ang;
      end else begin
         nxt.x = cur.x + (cur.y >>> s);
         nxt.y = cur.y - (cur.x >>> s);
         nxt.t = cur.t + ang;
      end
      return nxt;
   endfunction

endpackage

>>> hdl/vcst_isqrt.sv
// ----------------------------------------------------------------------------
// vcst_isqrt
// Pipelined integer square root of the squared distance, two root bits per
// stage; the caller carries valid and sideband alongside.
// ----------------------------------------------------------------------------
module vcst_isqrt (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [vcst_pkg::D2_W-1:0]     radicand,
   output logic [vcst_pkg::ROOT_W-1:0]   root
);

   localparam int PAD_W = 2 * vcst_pkg::ROOT_W;

   vcst_pkg::sq_type   sq_ff  [vcst_pkg::SQRT_STAGES];
   logic [PAD_W-1:0]   rad_ff [vcst_pkg::SQRT_STAGES];

   genvar j;
   for (j = 0; j < vcst_pkg::SQRT_STAGES; j++) begin : g_stage
      vcst_pkg::sq_type sq_cur;
      vcst_pkg::sq_type sq_mid;
      vcst_pkg::sq_type sq_in;
      logic [PAD_W-1:0] rad_cur;
      logic [PAD_W-1:0] rad_in;

      if (j == 0) begin : g_first
         assign sq_cur  = '0;
         assign rad_cur = PAD_W'(radicand);
      end else begin : g_next
         assign sq_cur  = sq_ff[j-1];
         assign rad_cur = rad_ff[j-1];
      end

      always_comb begin
         sq_mid = vcst_pkg::sqrt_step(sq_cur, rad_cur[PAD_W-1 -: 2]);
         sq_in  = vcst_pkg::sqrt_step(sq_mid, rad_cur[PAD_W-3 -: 2]);
         rad_in = {rad_cur[PAD_W-5:0], 4'b0000};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sq_ff[j]  <= sq_in;
            rad_ff[j] <= rad_in;
         end
      end
   end

   assign root = sq_ff[vcst_pkg::SQRT_STAGES-1].root;

endmodule

>>> hdl/view_cone_sphere_test_core.sv
// ----------------------------------------------------------------------------
// view_cone_sphere_test_core
// Streaming view-cone test: one sphere in, one in-view flag out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sphere per beat (centre Q16.16, radius unsigned Q15.16),
//            accepted when req_valid is high and req_stall is low.
//   rsp_*  : one in_view flag per sphere, same order, taken when rsp_valid
//            is high and rsp_stall is low.
//   csr_*  : register writes (camera position, forward vector, field of
//            view); csr_ready is always high. Write only while idle.
//   Throughput: one beat per cycle while no held result stalls the
//            pipeline; its depth is set by the 17-stage square root and
//            the two CORDIC chains.
//   Stall: a stalled result holds the whole pipeline; req_stall rises in
//            the same cycle, so nothing is dropped or repeated.
//   Reset: synchronous, active high; flushes all valid bits and loads the
//            register defaults (camera at origin, forward +z, fov pi/2).
// ----------------------------------------------------------------------------
module view_cone_sphere_test_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [vcst_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [vcst_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [vcst_pkg::POS_W-1:0] req_pos_z,
   input  logic [vcst_pkg::RAD_W-1:0]        req_sphere_radius,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_in_view,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [31:0]                       csr_wdata
);

   localparam int N = vcst_pkg::CORDIC_STEPS;
   localparam int S = vcst_pkg::SQRT_STAGES;

   // sideband carried alongside the square root
   typedef struct packed {
      logic                               v;
      logic                               near;
      logic [vcst_pkg::RAD_W-1:0]         r;
      logic signed [vcst_pkg::DOT_W-1:0]  dot;
   } sq_side_type;

   // sideband carried alongside both CORDIC chains
   typedef struct packed {
      logic                               v;
      logic                               near;
      logic                               flag;   // d > r, then cosine sign
      logic [vcst_pkg::ROOT_W-1:0]        d;
      logic signed [vcst_pkg::DOT_W-1:0]  dot;
   } cr_side_type;

   // ---------------- configuration registers ----------------
   logic signed [vcst_pkg::POS_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [vcst_pkg::FWD_W-1:0] fwd_x_ff, fwd_y_ff, fwd_z_ff;
   logic [vcst_pkg::FOV_W-1:0]        fov_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         fwd_x_ff <= '0;
         fwd_y_ff <= '0;
         fwd_z_ff <= 16'sd16384;
         fov_ff   <= 15'd12868;
      end else if (csr_valid && csr_ready) begin
         unique case (vcst_pkg::csr_index_type'(csr_index))
            vcst_pkg::CSR_CAM_X: cam_x_ff <= csr_wdata;
            vcst_pkg::CSR_CAM_Y: cam_y_ff <= csr_wdata;
            vcst_pkg::CSR_CAM_Z: cam_z_ff <= csr_wdata;
            vcst_pkg::CSR_FWD_X: fwd_x_ff <= csr_wdata[15:0];
            vcst_pkg::CSR_FWD_Y: fwd_y_ff <= csr_wdata[15:0];
            vcst_pkg::CSR_FWD_Z: fwd_z_ff <= csr_wdata[15:0];
            vcst_pkg::CSR_FOV:   fov_ff   <= csr_wdata[14:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // ---------------- global advance ----------------
   // The whole pipeline moves unless a finished result is held by the receiver.
   logic rsp_valid_ff;
   logic rsp_in_view_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------- stage 1: offset from camera ----------------
   logic                               v1_ff;
   logic signed [vcst_pkg::OFS_W-1:0]  ox1_ff, oy1_ff, oz1_ff;
   logic [vcst_pkg::RAD_W-1:0]         r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox1_ff <= 33'(req_pos_x) - 33'(cam_x_ff);
         oy1_ff <= 33'(req_pos_y) - 33'(cam_y_ff);
         oz1_ff <= 33'(req_pos_z) - 33'(cam_z_ff);
         r1_ff  <= req_sphere_radius;
      end
   end

   // ---------------- stage 2: partial products ----------------
   // Split each magnitude into 17 + 16 bits so no squaring multiplier exceeds 17x17.
   logic [vcst_pkg::OFS_W-1:0] mag_x, mag_y, mag_z;

   assign mag_x = ox1_ff[vcst_pkg::OFS_W-1] ? 33'(-ox1_ff) : 33'(ox1_ff);
   assign mag_y = oy1_ff[vcst_pkg::OFS_W-1] ? 33'(-oy1_ff) : 33'(oy1_ff);
   assign mag_z = oz1_ff[vcst_pkg::OFS_W-1] ? 33'(-oz1_ff) : 33'(oz1_ff);

   logic                               v2_ff;
   logic [vcst_pkg::RAD_W-1:0]         r2_ff;
   logic [33:0]                        hh_ff [3];
   logic [32:0]                        hl_ff [3];
   logic [31:0]                        ll_ff [3];
   logic signed [vcst_pkg::TERM_W-1:0] tx2_ff, ty2_ff, tz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff    <= r1_ff;
         hh_ff[0] <= 34'(mag_x[32:16]) * 34'(mag_x[32:16]);
         hl_ff[0] <= 33'(mag_x[32:16]) * 33'(mag_x[15:0]);
         ll_ff[0] <= 32'(mag_x[15:0])  * 32'(mag_x[15:0]);
         hh_ff[1] <= 34'(mag_y[32:16]) * 34'(mag_y[32:16]);
         hl_ff[1] <= 33'(mag_y[32:16]) * 33'(mag_y[15:0]);
         ll_ff[1] <= 32'(mag_y[15:0])  * 32'(mag_y[15:0]);
         hh_ff[2] <= 34'(mag_z[32:16]) * 34'(mag_z[32:16]);
         hl_ff[2] <= 33'(mag_z[32:16]) * 33'(mag_z[15:0]);
         ll_ff[2] <= 32'(mag_z[15:0])  * 32'(mag_z[15:0]);
         tx2_ff   <= 49'(ox1_ff) * 49'(fwd_x_ff);
         ty2_ff   <= 49'(oy1_ff) * 49'(fwd_y_ff);
         tz2_ff   <= 49'(oz1_ff) * 49'(fwd_z_ff);
      end
   end

   // ---------------- stage 3: squared distance and dot ----------------
   logic [vcst_pkg::D2_W-1:0] sq_sum [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_sum[k] = {hh_ff[k], 32'd0} + {16'd0, hl_ff[k], 17'd0} + 66'(ll_ff[k]);
      end
   end

   logic                               v3_ff;
   logic [vcst_pkg::RAD_W-1:0]         r3_ff;
   logic [vcst_pkg::D2_W-1:0]          d2_ff;
   logic signed [vcst_pkg::DOT_W-1:0]  dot3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r3_ff   <= r2_ff;
         d2_ff   <= sq_sum[0] + sq_sum[1] + sq_sum[2];
         dot3_ff <= 51'(tx2_ff) + 51'(ty2_ff) + 51'(tz2_ff);
      end
   end

   // ---------------- square root pipeline ----------------
   logic [vcst_pkg::ROOT_W-1:0] root;
   sq_side_type                 sqs_ff [S];

   vcst_isqrt u_isqrt (
      .clock    (clock),
      .enable   (en),
      .radicand (d2_ff),
      .root     (root)
   );

   genvar i;
   for (i = 0; i < S; i++) begin : g_sq_side
      sq_side_type sqs_in;
      if (i == 0) begin : g_first
         always_comb begin
            sqs_in.v    = v3_ff;
            sqs_in.near = (d2_ff < vcst_pkg::NEAR_D2);
            sqs_in.r    = r3_ff;
            sqs_in.dot  = dot3_ff;
         end
      end else begin : g_next
         assign sqs_in = sqs_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqs_ff[i] <= '0;
         end else if (en) begin
            sqs_ff[i] <= sqs_in;
         end
      end
   end

   // ---------------- angular radius: CORDIC vectoring ----------------
   vcst_pkg::ac_type ac_ff  [N];
   cr_side_type      acs_ff [N];

   for (i = 0; i < N; i++) begin : g_atan
      vcst_pkg::ac_type ac_cur;
      cr_side_type      acs_cur;
      if (i == 0) begin : g_first
         always_comb begin
            ac_cur.x     = $signed(37'(root));
            ac_cur.y     = $signed(37'(sqs_ff[S-1].r));
            ac_cur.z     = '0;
            acs_cur.v    = sqs_ff[S-1].v;
            acs_cur.near = sqs_ff[S-1].near;
            acs_cur.flag = (root > 34'(sqs_ff[S-1].r));
            acs_cur.d    = root;
            acs_cur.dot  = sqs_ff[S-1].dot;
         end
      end else begin : g_next
         assign ac_cur  = ac_ff[i-1];
         assign acs_cur = acs_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ac_ff[i] <= vcst_pkg::atan_step(ac_cur, 5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            acs_ff[i] <= '0;
         end else if (en) begin
            acs_ff[i] <= acs_cur;
         end
      end
   end

   // ---------------- cone angle and fold to the first quadrant ----------------
   logic signed [vcst_pkg::CT_W-1:0] ang_a;
   logic signed [vcst_pkg::CT_W-1:0] theta;
   logic signed [vcst_pkg::CT_W-1:0] fold1;
   logic signed [vcst_pkg::CT_W-1:0] fold2;
   logic                             flip;
   cr_side_type                      ts_in;

   always_comb begin
      ang_a = acs_ff[N-1].flag ? 21'(ac_ff[N-1].z) : vcst_pkg::PI_Q16;
      theta = $signed({4'b0000, fov_ff, 2'b00}) + ang_a;
      fold1 = (theta > vcst_pkg::PI_Q16) ? vcst_pkg::TWO_PI_Q16 - theta : theta;
      flip  = (fold1 > vcst_pkg::HALF_PI_Q16);
      fold2 = flip ? vcst_pkg::PI_Q16 - fold1 : fold1;
      ts_in      = acs_ff[N-1];
      ts_in.flag = flip;   // from here on, flag marks a negative cosine
   end

   logic signed [vcst_pkg::CT_W-1:0] t_ff;
   cr_side_type                      ts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= '0;
      end else if (en) begin
         ts_ff <= ts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= fold2;
      end
   end

   // ---------------- cosine: CORDIC rotation ----------------
   vcst_pkg::cc_type cc_ff  [N];
   cr_side_type      ccs_ff [N];

   for (i = 0; i < N; i++) begin : g_cos
      vcst_pkg::cc_type cc_cur;
      cr_side_type      ccs_cur;
      if (i == 0) begin : g_first
         always_comb begin
            cc_cur.x = vcst_pkg::GAIN_Q30;
            cc_cur.y = '0;
            cc_cur.t = t_ff;
            ccs_cur  = ts_ff;
         end
      end else begin : g_next
         assign cc_cur  = cc_ff[i-1];
         assign ccs_cur = ccs_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cc_ff[i] <= vcst_pkg::cos_step(cc_cur, 5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ccs_ff[i] <= '0;
         end else if (en) begin
            ccs_ff[i] <= ccs_cur;
         end
      end
   end

   // ---------------- round, clamp and sign the cosine ----------------
   logic [17:0]                        cos_rnd;
   logic [17:0]                        cos_mag;
   logic signed [vcst_pkg::COS_W-1:0]  cos_in;
   logic signed [vcst_pkg::CX_W-1:0]   cx_last;

   always_comb begin
      cx_last = cc_ff[N-1].x;
      cos_rnd = (cx_last > 0) ? 18'((cx_last + 34'sd32768) >>> 16) : 18'd0;
      cos_mag = (cos_rnd > vcst_pkg::COS_ONE) ? vcst_pkg::COS_ONE : cos_rnd;
      cos_in  = ccs_ff[N-1].flag ? -$signed(16'(cos_mag)) : $signed(16'(cos_mag));
   end

   logic signed [vcst_pkg::COS_W-1:0] cos_ff;
   cr_side_type                       cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= '0;
      end else if (en) begin
         cs_ff <= ccs_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
      end
   end

   // ---------------- threshold product cos * d ----------------
   logic                               vp_ff;
   logic                               nearp_ff;
   logic signed [vcst_pkg::DOT_W-1:0]  dotp_ff;
   logic signed [vcst_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (en) begin
         vp_ff <= cs_ff.v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nearp_ff <= cs_ff.near;
         dotp_ff  <= cs_ff.dot;
         prod_ff  <= 51'(cos_ff) * $signed({17'd0, cs_ff.d});
      end
   end

   // ---------------- output register: compare and hold ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_in_view_ff <= nearp_ff || (dotp_ff > prod_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_in_view = rsp_in_view_ff;

endmodule

>>> tb/sv/view_cone_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// view_cone_checker
// Watches the sphere and flag channels and the register port, predicts the
// in-view flag of every accepted sphere and compares it with each result beat.
// ----------------------------------------------------------------------------
module view_cone_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [vcst_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [vcst_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [vcst_pkg::POS_W-1:0]  req_pos_z,
   input  logic [vcst_pkg::RAD_W-1:0]         req_sphere_radius,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_in_view,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [31:0]                        csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count
);

   localparam longint ATAN_TAB [0:16] = '{51472, 30385, 16055, 8150, 4091, 2047,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

   longint      cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z;
   longint      fov;
   bit          flag_q[$];

   function automatic longint atan_at(int s);
      return (s <= 16) ? ATAN_TAB[s] : 0;
   endfunction

   // floor square root of a 66-bit value
   function automatic longint isqrt(logic [vcst_pkg::D2_W-1:0] v);
      logic [vcst_pkg::D2_W+1:0] c;
      logic [33:0]               r;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         r[b] = 1'b1;
         c = r * r;
         if (c > v) r[b] = 1'b0;
      end
      return longint'(r);
   endfunction

   function automatic longint sphere_angle(longint x, longint y);
      longint z, nx, ny;
      z = 0;
      for (int i = 0; i < vcst_pkg::CORDIC_STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> (i % 32)); ny = y - (x >>> (i % 32)); z += atan_at(i % 32);
         end else begin
            nx = x - (y >>> (i % 32)); ny = y + (x >>> (i % 32)); z -= atan_at(i % 32);
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function automatic longint cone_cos(longint t);
      longint x, y, nx, ny, c;
      bit     neg;
      x = 652032874; y = 0; neg = 0;
      if (t > 205887) t = 411775 - t;
      if (t > 102944) begin
         t = 205887 - t; neg = 1;
      end
      for (int i = 0; i < vcst_pkg::CORDIC_STEPS; i++) begin
         if (t >= 0) begin
            nx = x - (y >>> (i % 32)); ny = y + (x >>> (i % 32)); t -= atan_at(i % 32);
         end else begin
            nx = x + (y >>> (i % 32)); ny = y - (x >>> (i % 32)); t += atan_at(i % 32);
         end
         x = nx; y = ny;
      end
      c = (x > 0) ? ((x + 32768) >>> 16) : 0;
      if (c > 16384) c = 16384;
      return neg ? -c : c;
   endfunction

   function automatic bit predict_in_view(longint px, longint py, longint pz, longint r);
      longint                    ox, oy, oz, d, dot, a, c;
      logic [vcst_pkg::D2_W-1:0] d2;
      ox = px - cam_x; oy = py - cam_y; oz = pz - cam_z;
      // squares of the magnitudes, exact in 66 bits
      d2 = vcst_pkg::D2_W'($unsigned(ox < 0 ? -ox : ox))
         * vcst_pkg::D2_W'($unsigned(ox < 0 ? -ox : ox))
         + vcst_pkg::D2_W'($unsigned(oy < 0 ? -oy : oy))
         * vcst_pkg::D2_W'($unsigned(oy < 0 ? -oy : oy))
         + vcst_pkg::D2_W'($unsigned(oz < 0 ? -oz : oz))
         * vcst_pkg::D2_W'($unsigned(oz < 0 ? -oz : oz));
      if (d2 < vcst_pkg::NEAR_D2) return 1'b1;
      d   = isqrt(d2);
      dot = ox * fwd_x + oy * fwd_y + oz * fwd_z;
      a   = (d > r) ? sphere_angle(d, r) : 205887;
      c   = cone_cos((fov << 2) + a);
      return dot > c * d;
   endfunction

   assign pending_count = flag_q.size();

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         cam_x <= 0; cam_y <= 0; cam_z <= 0;
         fwd_x <= 0; fwd_y <= 0; fwd_z <= 16384; fov <= 12868;
         fail_count <= 0;
         flag_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vcst_pkg::CSR_CAM_X: cam_x <= longint'($signed(csr_wdata));
               vcst_pkg::CSR_CAM_Y: cam_y <= longint'($signed(csr_wdata));
               vcst_pkg::CSR_CAM_Z: cam_z <= longint'($signed(csr_wdata));
               vcst_pkg::CSR_FWD_X: fwd_x <= longint'($signed(csr_wdata[15:0]));
               vcst_pkg::CSR_FWD_Y: fwd_y <= longint'($signed(csr_wdata[15:0]));
               vcst_pkg::CSR_FWD_Z: fwd_z <= longint'($signed(csr_wdata[15:0]));
               vcst_pkg::CSR_FOV:   fov   <= longint'(csr_wdata[14:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            flag_q.push_back(predict_in_view(req_pos_x, req_pos_y, req_pos_z,
                                             longint'(req_sphere_radius)));
         if (rsp_valid && !rsp_stall) begin
            if (flag_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual in_view=%0b",
                        $time, rsp_in_view);
               fail_count <= fail_count + 1;
            end else begin
               want = flag_q.pop_front();
               if (rsp_in_view !== want) begin
                  $display("%0t: in_view expected %0b, actual %0b", $time, want,
                           rsp_in_view);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives spheres and register writes into the view-cone core with random
// gaps and result stalls; the checker predicts and compares every flag.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LATENCY   = 24 + 2 * vcst_pkg::CORDIC_STEPS;
   localparam int IDLE_STOP = 4000;

   logic                              clock, reset;
   logic                              req_valid, req_stall;
   logic signed [vcst_pkg::POS_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic [vcst_pkg::RAD_W-1:0]        req_sphere_radius;
   logic                              rsp_valid, rsp_stall, rsp_in_view;
   logic                              csr_valid, csr_ready;
   logic [2:0]                        csr_index;
   logic [31:0]                       csr_wdata;
   int                                fail_count, pending_count;
   int                                quiet_cycles;
   bit                                stall_enable;

   view_cone_sphere_test_core uut (.*);

   view_cone_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: count cycles with no beat on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_STOP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: while stalls are enabled, raise rsp_stall for a random gap before most beats.
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         gap = stall_enable ? $urandom_range(0, 15) : 0;
         repeat (gap) @(posedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
         rsp_stall <= (stall_enable && $urandom_range(0, 15) != 0);
      end
   end

   // Hold the write until the core takes it; the caller drops csr_valid.
   task automatic write_reg(vcst_pkg::csr_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock iff csr_ready);
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
   endtask

   // Drain outstanding spheres before touching the registers.
   task automatic settle();
      wait (pending_count == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Send one sphere; hold it until the core takes the beat.
   task automatic send_sphere(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [30:0] r, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pos_x         <= px;
      req_pos_y         <= py;
      req_pos_z         <= pz;
      req_sphere_radius <= r;
      @(posedge clock iff !req_stall);
   endtask

   task automatic send_idle();
      req_valid <= 1'b0;
   endtask

   task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                             logic [14:0] fov);
      write_reg(vcst_pkg::CSR_CAM_X, cx);
      write_reg(vcst_pkg::CSR_CAM_Y, cy);
      write_reg(vcst_pkg::CSR_CAM_Z, cz);
      write_reg(vcst_pkg::CSR_FWD_X, {16'h0, fx});
      write_reg(vcst_pkg::CSR_FWD_Y, {16'h0, fy});
      write_reg(vcst_pkg::CSR_FWD_Z, {16'h0, fz});
      write_reg(vcst_pkg::CSR_FOV, {17'h0, fov});
      csr_idle();
   endtask

   // Small signed coordinate near the camera, Q16.16 within about +-64.
   function automatic logic [31:0] near_coord(logic [31:0] base);
      return base + $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
   endfunction

   initial begin
      logic [31:0] cx, cy, cz, px, py, pz;
      logic [30:0] r;
      int          mode;
      reset = 1'b1;
      req_valid = 1'b0; req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      req_sphere_radius = '0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      stall_enable = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults first, then extremes of every field.
      send_sphere(32'h0, 32'h0, 32'h0001_0000, 31'h0, 0);
      send_sphere(32'h0, 32'h0, 32'h0, 31'h0, 0);             // sphere at the camera
      send_sphere(32'h0, 32'h0, 32'h0000_0006, 31'h0, 0);     // just inside the near limit
      send_sphere(32'h0, 32'h0, 32'h0000_0007, 31'h0, 0);     // just outside it
      send_sphere(32'h0, 32'h0, 32'hFFFF_0000, 31'h0, 0);     // behind the camera
      send_sphere(32'h0, 32'h0, 32'hFFFF_0000, 31'h0002_0000, 0); // radius over distance
      send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 0);
      send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF, 0);
      send_sphere(32'h0001_0000, 32'h0, 32'h0001_0000, 31'h0, 0); // on the cone edge
      send_idle();
      settle();

      // Extreme camera: far corner, skewed non-unit forward, fov of zero.
      set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 16'h8000, 16'h7FFF, 16'hC000, 15'd0);
      send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 0);
      send_sphere(32'h0, 32'h0, 32'h0, 31'h0000_1000, 0);
      send_idle();
      settle();

      // Field of view at pi and at the 15-bit maximum.
      set_camera(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 15'd25736);
      send_sphere(32'hFFFF_0000, 32'h0, 32'h0, 31'h0, 0);
      send_sphere(32'h0, 32'h0001_0000, 32'h0, 31'h100, 0);
      send_idle();
      settle();
      write_reg(vcst_pkg::CSR_FOV, 32'h0000_7FFF);
      csr_idle();
      send_sphere(32'hFFFF_0000, 32'h0, 32'h0, 31'h0, 0);
      send_sphere(32'h0001_0000, 32'h0, 32'h0, 31'h0, 0);
      send_idle();
      settle();

      // Random phases: new camera each phase, mostly nearby spheres.
      for (int phase = 0; phase < 16; phase++) begin
         cx = (phase % 4 == 0) ? $urandom : near_coord(32'h0);
         cy = (phase % 4 == 0) ? $urandom : near_coord(32'h0);
         cz = (phase % 4 == 0) ? $urandom : near_coord(32'h0);
         set_camera(cx, cy, cz, 16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384),
                    (phase % 5 == 0) ? 15'($urandom) : 15'($urandom_range(0, 25736)));
         stall_enable = (phase % 3 != 1);
         for (int n = 0; n < 100; n++) begin
            mode = $urandom_range(0, 9);
            px = near_coord(cx); py = near_coord(cy); pz = near_coord(cz);
            r  = 31'($urandom_range(0, 32'h0040_0000));
            if (mode == 0) begin
               px = $urandom; py = $urandom; pz = $urandom; r = 31'($urandom);
            end else if (mode == 1) begin
               px = cx + $urandom_range(0, 12) - 6; py = cy; pz = cz;
            end else if (mode == 2) begin
               r = 31'($urandom);
            end
            send_sphere(px, py, pz, r, stall_enable && (n % 20 < 14));
         end
         send_idle();
         settle();
      end

      wait (pending_count == 0);
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
